>>> rtl/cpe_pkg.sv
// cpe_pkg: widths, constants and shared types of the windowed energy block.
// No dependencies; used by every module under rtl/.
`default_nettype none

package cpe_pkg;

  localparam int SAMPLE_W  = 16;  // signed Q1.15 sample
  localparam int WEIGHT_W  = 16;  // unsigned Q1.15 weight
  localparam int SQ_W      = 31;  // one square, at most 2^30
  localparam int SUMSQ_W   = 33;  // four squares, at most 2^32
  localparam int PROD_W    = WEIGHT_W + SUMSQ_W;
  localparam int ENERGY_SH = 16;  // p/2 weighting: drop 16 bits
  localparam int ENERGY_W  = 32;
  localparam int TOTAL_W   = 36;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'h8000;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ENERGY_W-1:0] energy_t;
  typedef logic [TOTAL_W-1:0]  total_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

>>> rtl/cpe_fifo.sv
// cpe_fifo: short queue of energies between the front and back parts.
// Depends on cpe_pkg for depth and the status struct.
`default_nettype none

module cpe_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire cpe_pkg::energy_t push_data,
  input  wire logic             pop,
  output cpe_pkg::energy_t      pop_data,
  output cpe_pkg::q_status_t    status
);

  cpe_pkg::energy_t                    mem_r [cpe_pkg::QUEUE_DEPTH];
  logic [cpe_pkg::QPTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [cpe_pkg::QPTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [cpe_pkg::QCNT_W-1:0]          count_r,  count_nxt;

  function automatic logic [cpe_pkg::QPTR_W-1:0] ptr_inc(
    input logic [cpe_pkg::QPTR_W-1:0] p
  );
    if (p == cpe_pkg::QPTR_W'(cpe_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + cpe_pkg::QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + cpe_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - cpe_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == cpe_pkg::QCNT_W'(cpe_pkg::QUEUE_DEPTH));

  // front credit scheme must never overrun the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("cpe_fifo: push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("cpe_fifo: pop from empty queue");

endmodule

`default_nettype wire

>>> rtl/cpe_front.sv
// cpe_front: accepts samples, holds the weight register and computes the
// weighted energy in three stages. Depends on cpe_pkg.
`default_nettype none

module cpe_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [cpe_pkg::SAMPLE_W-1:0] in_cur_re,
  input  wire logic signed [cpe_pkg::SAMPLE_W-1:0] in_cur_im,
  input  wire logic signed [cpe_pkg::SAMPLE_W-1:0] in_lag_re,
  input  wire logic signed [cpe_pkg::SAMPLE_W-1:0] in_lag_im,
  input  wire logic                           cfg_wr_en,
  input  wire logic [cpe_pkg::WEIGHT_W-1:0]   cfg_wr_data,
  input  wire cpe_pkg::q_status_t             q_status,
  output logic                                q_push,
  output cpe_pkg::energy_t                    q_push_data
);

  localparam int OCC_W = cpe_pkg::QCNT_W + 1;

  logic [cpe_pkg::WEIGHT_W-1:0] weight_r;

  logic                          s1_valid_r, s2_valid_r, s3_valid_r;
  logic [cpe_pkg::SQ_W-1:0]      s1_sq_r [4];
  logic [cpe_pkg::SUMSQ_W-1:0]   s2_sumsq_r;
  cpe_pkg::energy_t              s3_energy_r;

  logic signed [2*cpe_pkg::SAMPLE_W-1:0] prod_sq [4];
  logic [cpe_pkg::SUMSQ_W-1:0]           sumsq_nxt;
  logic [cpe_pkg::PROD_W-1:0]            wprod_nxt;
  logic [OCC_W-1:0]                      occupancy;
  logic                                  accept;

  // every item already in the pipe holds a slot in the queue
  assign occupancy = OCC_W'(q_status.count) + OCC_W'(s1_valid_r)
                   + OCC_W'(s2_valid_r) + OCC_W'(s3_valid_r);
  assign in_stall  = (occupancy >= OCC_W'(cpe_pkg::QUEUE_DEPTH));
  assign accept    = in_valid && !in_stall;

  always_comb begin
    prod_sq[0] = in_cur_re * in_cur_re;
    prod_sq[1] = in_cur_im * in_cur_im;
    prod_sq[2] = in_lag_re * in_lag_re;
    prod_sq[3] = in_lag_im * in_lag_im;
    sumsq_nxt  = cpe_pkg::SUMSQ_W'(s1_sq_r[0]) + cpe_pkg::SUMSQ_W'(s1_sq_r[1])
               + cpe_pkg::SUMSQ_W'(s1_sq_r[2]) + cpe_pkg::SUMSQ_W'(s1_sq_r[3]);
    wprod_nxt  = cpe_pkg::PROD_W'(weight_r) * cpe_pkg::PROD_W'(s2_sumsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r   <= cpe_pkg::WEIGHT_RESET;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        weight_r <= cfg_wr_data;
      end
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        s1_sq_r[i] <= prod_sq[i][cpe_pkg::SQ_W-1:0];
      end
    end
    s2_sumsq_r  <= sumsq_nxt;
    s3_energy_r <= wprod_nxt[cpe_pkg::ENERGY_SH +: cpe_pkg::ENERGY_W];
  end

  assign q_push      = s3_valid_r;
  assign q_push_data = s3_energy_r;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= OCC_W'(cpe_pkg::QUEUE_DEPTH))
    else $error("cpe_front: more items in flight than queue slots");

endmodule

`default_nettype wire

>>> rtl/cpe_back.sv
// cpe_back: energy delay line, running total and output register.
// Depends on cpe_pkg; fed from cpe_fifo.
`default_nettype none

module cpe_back #(
  parameter int WINDOW = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cpe_pkg::q_status_t q_status,
  input  wire cpe_pkg::energy_t   q_pop_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cpe_pkg::total_t         out_window_energy
);

  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  cpe_pkg::energy_t    hist_mem [WINDOW];
  logic [POS_W-1:0]    pos_r;
  logic                wrapped_r;

  logic                b1_valid_r;
  logic                b1_wrapped_r;
  cpe_pkg::energy_t    b1_energy_r;
  cpe_pkg::energy_t    b1_oldest_r;

  cpe_pkg::total_t     total_r, total_nxt;
  cpe_pkg::total_t     out_data_r;
  logic                out_valid_r;

  logic                out_ready;
  logic                b1_adv;
  logic                pos_last;
  cpe_pkg::energy_t    oldest;

  assign out_ready = !out_valid_r || !out_stall;
  assign b1_adv    = b1_valid_r && out_ready;
  assign q_pop     = !q_status.empty && (!b1_valid_r || b1_adv);
  assign pos_last  = (pos_r == POS_W'(WINDOW - 1));

  // untouched entries before the first wrap count as zero
  assign oldest    = b1_wrapped_r ? b1_oldest_r : '0;
  assign total_nxt = total_r + cpe_pkg::TOTAL_W'(b1_energy_r)
                   - cpe_pkg::TOTAL_W'(oldest);

  // read-before-write at the same slot
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hist_mem[pos_r] <= q_pop_data;
      b1_oldest_r     <= hist_mem[pos_r];
      b1_energy_r     <= q_pop_data;
      b1_wrapped_r    <= wrapped_r;
    end
    if (b1_adv) begin
      out_data_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      wrapped_r   <= 1'b0;
      b1_valid_r  <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pos_r <= pos_last ? '0 : pos_r + POS_W'(1);
        if (pos_last) begin
          wrapped_r <= 1'b1;
        end
      end
      if (q_pop) begin
        b1_valid_r <= 1'b1;
      end else if (b1_adv) begin
        b1_valid_r <= 1'b0;
      end
      if (b1_adv) begin
        total_r     <= total_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_window_energy = out_data_r;

  a_b1_held: assert property (@(posedge clk) disable iff (!rst_n)
    b1_valid_r && !out_ready |=> b1_valid_r && $stable(b1_energy_r))
    else $error("cpe_back: staged energy lost while output stalled");

endmodule

`default_nettype wire

>>> rtl/cp_energy_moving_sum.sv
// cp_energy_moving_sum: top level of the windowed energy term of the
// cyclic-prefix ML timing metric. Depends on cpe_pkg, cpe_front, cpe_fifo
// and cpe_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction carries r(k) as
//   in_cur_re/in_cur_im and r(k-N) as in_lag_re/in_lag_im, signed Q1.15.
//   Output channel (out_valid / out_stall): one transaction per input, with
//   out_window_energy = sum of the last WINDOW weighted energies, 36 bits,
//   Q2.30 units, modulo 2^36 for WINDOW above 16.
//   cfg_wr_en / cfg_wr_data write the weight p (unsigned Q1.15); change it
//   only while the block is idle. Stored energies keep their old weight.
// Timing:
//   Squares are registered at the accepting edge, then come the sum, weight
//   multiply, queue write, delay-line read, and total update into the
//   output register. New inputs are accepted while earlier ones are in
//   flight: each one holds one of the four queue credits from its accepting
//   edge until its queue pop, and the registered queue count then frees
//   the credit for a new input.
//   The delay line is a WINDOW-entry memory, one read and one write a cycle when the queue pops.
// Reset (rst_n low, synchronous): weight p = 1.0, total zero, queue empty;
//   a wrap flag makes unwritten delay-line entries read as zero, so no
//   clearing pass is needed and samples are taken right after reset.
// Backpressure: with out_stall high the result holds; the queue absorbs
//   in-flight items and in_stall rises once every queue slot is spoken for.
`default_nettype none

module cp_energy_moving_sum #(
  parameter int WINDOW = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [cpe_pkg::SAMPLE_W-1:0] in_cur_re,
  input  wire logic signed [cpe_pkg::SAMPLE_W-1:0] in_cur_im,
  input  wire logic signed [cpe_pkg::SAMPLE_W-1:0] in_lag_re,
  input  wire logic signed [cpe_pkg::SAMPLE_W-1:0] in_lag_im,
  input  wire logic                                cfg_wr_en,
  input  wire logic [cpe_pkg::WEIGHT_W-1:0]        cfg_wr_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [cpe_pkg::TOTAL_W-1:0]              out_window_energy
);

  // front -> queue
  logic                q_push;
  cpe_pkg::energy_t    q_push_data;
  // queue -> back
  logic                q_pop;
  cpe_pkg::energy_t    q_pop_data;
  cpe_pkg::q_status_t  q_status;

  // front: weight register, squares, sum, weight multiply, credit stall
  cpe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cur_re   (in_cur_re),
    .in_cur_im   (in_cur_im),
    .in_lag_re   (in_lag_re),
    .in_lag_im   (in_lag_im),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // decouples the fixed-latency front from the stallable back
  cpe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  // back: delay line, running total, output register
  cpe_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .q_pop_data        (q_pop_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_energy (out_window_energy)
  );

endmodule

`default_nettype wire

>>> sim/tb_cp_energy_moving_sum.sv
// Self-checking testbench for cp_energy_moving_sum: directed and random samples,
// several weight settings, random input gaps and output stalls.
// Depends on cpe_pkg and the RTL under rtl/.

module tb_cp_energy_moving_sum;

  localparam int WIN           = 16;       // window length under test
  localparam int DRAIN_CYCLES  = 12;       // drain margin after the last owed result
  localparam int HOLD_CYCLES   = 120;      // long output hold-off
  localparam int TIMEOUT_TICKS = 4000000;  // watchdog delay in simulation time units
  localparam int MAX_PRINTS    = 40;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY
  } stall_mode_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // DUT ports; all inputs known from time zero
  logic                                in_valid    = 1'b0;
  logic                                in_stall;
  logic signed [cpe_pkg::SAMPLE_W-1:0] in_cur_re   = '0;
  logic signed [cpe_pkg::SAMPLE_W-1:0] in_cur_im   = '0;
  logic signed [cpe_pkg::SAMPLE_W-1:0] in_lag_re   = '0;
  logic signed [cpe_pkg::SAMPLE_W-1:0] in_lag_im   = '0;
  logic                                cfg_wr_en   = 1'b0;
  logic [cpe_pkg::WEIGHT_W-1:0]        cfg_wr_data = '0;
  logic                                out_valid;
  logic                                out_stall   = 1'b0;
  cpe_pkg::total_t                     out_window_energy;

  cp_energy_moving_sum #(
    .WINDOW(WIN)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cur_re        (in_cur_re),
    .in_cur_im        (in_cur_im),
    .in_lag_re        (in_lag_re),
    .in_lag_im        (in_lag_im),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_window_energy(out_window_energy)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the delay line, total and weight.
  // ---------------------------------------------------------------------------
  cpe_pkg::energy_t             energy_line [WIN];
  cpe_pkg::total_t              window_total = '0;
  int                           line_pos     = 0;
  logic [cpe_pkg::WEIGHT_W-1:0] weight_q15   = cpe_pkg::WEIGHT_RESET;

  // Totals still owed by the block, oldest first.
  cpe_pkg::total_t expected_totals[$];

  int error_count     = 0;
  int results_checked = 0;
  int samples_sent    = 0;
  int weights_used    = 1;   // reset weight counts as a setting
  int stalled_inputs  = 0;   // cycles the block pushed back on the sender

  // sender pacing
  int burst_left = 0;
  int gap_max    = 0;

  // receiver pacing; hold_request is a one-shot ask from the test sequence
  int          hold_request = 0;
  int          hold_left    = 0;
  stall_mode_t stall_mode   = STALL_NONE;
  int          mode_left    = 0;
  int          stall_tick   = 0;

  initial begin
    for (int i = 0; i < WIN; i++) energy_line[i] = '0;
  end

  // Square of a signed Q1.15 value; at most 2^30, so never negative in 32 bits.
  function automatic logic [31:0] square_q15(
    input logic signed [cpe_pkg::SAMPLE_W-1:0] v
  );
    logic signed [31:0] sq;
    sq = v * v;
    return sq;
  endfunction

  // Weighted energy of one sample pair, pushed through the delay line; the
  // return value is the new window total (wraps at 36 bits by construction).
  function automatic cpe_pkg::total_t predict_window_energy(
    input logic signed [cpe_pkg::SAMPLE_W-1:0] cr, ci, lr, li
  );
    logic [cpe_pkg::SUMSQ_W-1:0] sumsq;
    logic [cpe_pkg::PROD_W-1:0]  prod;
    cpe_pkg::energy_t            energy;
    sumsq = cpe_pkg::SUMSQ_W'(square_q15(cr)) + cpe_pkg::SUMSQ_W'(square_q15(ci))
          + cpe_pkg::SUMSQ_W'(square_q15(lr)) + cpe_pkg::SUMSQ_W'(square_q15(li));
    prod   = cpe_pkg::PROD_W'(weight_q15) * cpe_pkg::PROD_W'(sumsq);
    energy = prod[cpe_pkg::ENERGY_SH +: cpe_pkg::ENERGY_W];
    // oldest energy leaves, newest enters; old entries keep their old weight
    window_total = window_total + cpe_pkg::total_t'(energy)
                 - cpe_pkg::total_t'(energy_line[line_pos]);
    energy_line[line_pos] = energy;
    line_pos = (line_pos + 1) % WIN;
    return window_total;
  endfunction

  task automatic report_mismatch(input string what, input cpe_pkg::total_t got,
                                 input cpe_pkg::total_t want);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH t=%0t result #%0d: %s: got %0d, expected %0d",
               $time, results_checked, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction is matched against the oldest
  // expectation. Signals are read right after the edge, i.e. pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cpe_pkg::total_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_totals.size() == 0) begin
        report_mismatch("result with no sample pending", out_window_energy, '0);
      end else begin
        want = expected_totals.pop_front();
        if (out_window_energy !== want)
          report_mismatch("window_energy", out_window_energy, want);
        results_checked++;
      end
    end
    if (rst_n && in_valid && in_stall) stalled_inputs++;
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern. Modes change at random intervals so stalls
  // land on all pipeline phases; STALL_NONE gives clean streaming stretches.
  // A requested hold-off overrides the pattern and is counted down here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 9) < 2);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
        STALL_BURSTY: out_stall <= ((stall_tick % 11) < 4);
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Called at a rising edge; returns at the edge where the
  // transaction was accepted, or after the random gap that follows it.
  // Bursts of random length, random gaps between.
  task automatic send_sample(input logic signed [cpe_pkg::SAMPLE_W-1:0] cr, ci, lr, li);
    int gap;
    in_valid  <= 1'b1;
    in_cur_re <= cr;
    in_cur_im <= ci;
    in_lag_re <= lr;
    in_lag_im <= li;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_totals.push_back(predict_window_energy(cr, ci, lr, li));
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every owed result has arrived, plus a DRAIN_CYCLES margin.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Weight write; only called with the pipeline drained.
  task automatic write_weight(input logic [cpe_pkg::WEIGHT_W-1:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    weight_q15 = w;
    weights_used++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random sample with a bias toward the corners of the Q1.15 range.
  function automatic logic signed [cpe_pkg::SAMPLE_W-1:0] pick_sample(
    input int corner_pct
  );
    if ($urandom_range(0, 99) < corner_pct) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return cpe_pkg::SAMPLE_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence pieces
  // ---------------------------------------------------------------------------

  // Reset weight p = 1.0; window still warming up, so missing entries are zero.
  task automatic test_warmup_extremes();
    gap_max = 0;
    send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);  // largest sum of squares
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0001);
    send_sample(16'sh0001, 16'shFFFF, 16'sh0000, 16'sh8000);
    send_sample(16'sh5555, 16'shAAAA, 16'sh3333, 16'shCCCC);
    pause_until_drained();
  endtask

  // Weight extremes; a full window of maximum energy pushes the total to its
  // top, and older entries keep their old weight after each change.
  task automatic test_weight_extremes();
    write_weight(16'hFFFF);
    for (int i = 0; i < WIN; i++)
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    pause_until_drained();
    write_weight(16'h0000);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_sample(16'sh1234, 16'sh8000, 16'shFFFF, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    pause_until_drained();
    write_weight(16'h0001);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001);   // energy truncates to 0
    pause_until_drained();
  endtask

  // Long receiver hold-off while the sender streams: the internal queue fills
  // and in_stall must rise. After a full drain, a run with random gaps follows.
  task automatic test_backpressure();
    write_weight(cpe_pkg::WEIGHT_W'($urandom));
    gap_max      = 0;
    burst_left   = 1000;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 40; i++)
      send_sample(pick_sample(10), pick_sample(10), pick_sample(10), pick_sample(10));
    pause_until_drained();
    burst_left = 0;
    gap_max    = 3;
    for (int i = 0; i < 20; i++)
      send_sample(pick_sample(10), pick_sample(10), pick_sample(10), pick_sample(10));
    pause_until_drained();
  endtask

  // Random samples over several weight settings, extremes included; one
  // mid-phase pause lets the pipeline run dry with the delay line full.
  task automatic test_random_phases();
    logic [cpe_pkg::WEIGHT_W-1:0] phase_weight;
    int                           corner_pct;
    int                           pause_at;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       phase_weight = cpe_pkg::WEIGHT_RESET;
        1:       phase_weight = 16'hFFFF;
        2:       phase_weight = 16'h0000;
        3:       phase_weight = 16'h0001;
        default: phase_weight = cpe_pkg::WEIGHT_W'($urandom);
      endcase
      write_weight(phase_weight);
      corner_pct = (ph == 1) ? 60 : 15;
      gap_max    = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 12);
      pause_at   = $urandom_range(50, 230);
      for (int i = 0; i < 280; i++) begin
        if (i == pause_at) pause_until_drained();
        send_sample(pick_sample(corner_pct), pick_sample(corner_pct),
                    pick_sample(corner_pct), pick_sample(corner_pct));
      end
      pause_until_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_warmup_extremes();
    test_weight_extremes();
    test_backpressure();
    test_random_phases();

    pause_until_drained();
    $display("Covered %0d samples and %0d results over %0d weight settings,",
             samples_sent, results_checked, weights_used);
    $display("including full-window maximum energy and %0d cycles of input pushback.",
             stalled_inputs);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: generous bound on the whole run.
  initial begin
    #(TIMEOUT_TICKS);
    $display("Timeout with %0d results still owed", expected_totals.size());
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/cpe_pkg.sv
rtl/cpe_fifo.sv
rtl/cpe_front.sv
rtl/cpe_back.sv
rtl/cp_energy_moving_sum.sv
sim/tb_cp_energy_moving_sum.sv
